@@ src/itoa_pkg.sv @@
// Shared types, constants and helper functions for the integer to ASCII converter.
// Used by itoa_ctrl, itoa_dp and the integer_to_ascii_digits top level.
package itoa_pkg;

	localparam int unsigned ValueW     = 64;
	localparam int unsigned BaseW      = 6;
	localparam int unsigned CharW      = 8;
	localparam int unsigned DigitW     = 6;
	localparam int unsigned StackDepth = 64;
	localparam int unsigned DepthW     = $clog2(StackDepth + 1);
	localparam int unsigned ChunkBits  = 8;
	localparam int unsigned ChunkCnt   = ValueW / ChunkBits;
	localparam int unsigned ChunkW     = $clog2(ChunkCnt);
	localparam int unsigned ShiftW     = 3;
	localparam int unsigned MinBase    = 2;
	localparam int unsigned MaxBase    = 36;
	localparam int unsigned DecBase    = 10;
	localparam int unsigned HexDigits  = 16;
	localparam int unsigned HexShift   = 4;

	typedef logic [BaseW-1:0]  base_t;
	typedef logic [DigitW-1:0] digit_t;
	typedef logic [CharW-1:0]  char_t;
	typedef logic [DepthW-1:0] depth_t;
	typedef logic [ShiftW-1:0] shift_t;

	localparam char_t CharMinus = 8'h2D;
	localparam char_t CharNone  = 8'h00;
	localparam char_t CharZero  = 8'h30;
	localparam char_t CharUpA   = 8'h41;
	localparam char_t CharLowA  = 8'h61;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BAD,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_BAD,
		EMIT_SIGN,
		EMIT_DIGIT
	} emit_t;

	// controller -> datapath
	typedef struct packed {
		logic  load;
		logic  conv_step;
		emit_t emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad_in;
		logic conv_done;
		logic neg;
		logic out_free;
		logic last_digit;
	} status_t;

	// digit value to ASCII, lower or upper case letters above nine
	function automatic char_t digit_char(digit_t d, logic upper);
		char_t c;
		c = CharW'(d);
		if (d < DigitW'(DecBase)) begin
			return CharZero + c;
		end else if (upper) begin
			return CharUpA + c - CharW'(DecBase);
		end else begin
			return CharLowA + c - CharW'(DecBase);
		end
	endfunction

	// log2 of a power-of-two base, 0 for any other base
	function automatic shift_t pow2_shift(base_t b);
		shift_t s;
		case (b)
			6'd2:    s = 3'd1;
			6'd4:    s = 3'd2;
			6'd8:    s = 3'd3;
			6'd16:   s = 3'd4;
			6'd32:   s = 3'd5;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

endpackage

@@ src/itoa_ctrl.sv @@
// Controller state machine for the integer to ASCII converter.
// Depends on itoa_pkg; drives commands into itoa_dp and reads its status.
module itoa_ctrl import itoa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = status.bad_in ? ST_BAD : ST_CONV;
				end
			end
			ST_CONV: begin
				if (status.conv_done) begin
					state_d = status.neg ? ST_SIGN : ST_EMIT;
				end
			end
			ST_BAD: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SIGN: begin
				if (status.out_free) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free && status.last_digit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		cmd.load      = 1'b0;
		cmd.conv_step = 1'b0;
		cmd.emit      = EMIT_NONE;
		unique case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_CONV: cmd.conv_step = 1'b1;
			ST_BAD:  cmd.emit = status.out_free ? EMIT_BAD : EMIT_NONE;
			ST_SIGN: cmd.emit = status.out_free ? EMIT_SIGN : EMIT_NONE;
			ST_EMIT: cmd.emit = status.out_free ? EMIT_DIGIT : EMIT_NONE;
			default: cmd.emit = EMIT_NONE;
		endcase
	end

endmodule

@@ src/itoa_dp.sv @@
// Datapath: digit extraction (shift or byte-per-cycle division), digit stack, output register.
// Depends on itoa_pkg; steered by itoa_ctrl through cmd_t / status_t.
module itoa_dp import itoa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op,
	input  logic signed [63:0] value,
	input  base_t              base,
	input  cmd_t               cmd,
	output status_t            status,
	output logic               out_valid,
	input  logic               out_stall,
	output char_t              char_out,
	output logic               last,
	output logic               bad_base
);

	logic [ValueW-1:0] work_q;
	digit_t            rem_q;
	base_t             base_q;
	shift_t            shamt_q;
	logic              hex_q;
	logic              neg_q;
	logic [ChunkW-1:0] chunk_q;
	depth_t            depth_q;
	digit_t            stack_q [StackDepth];

	logic              out_valid_q;
	char_t             char_q;
	logic              last_q;
	logic              bad_q;

	logic              neg_in;
	logic [ValueW-1:0] work_pow;
	digit_t            digit_pow;
	logic [ValueW-1:0] work_div;
	digit_t            rem_div;
	logic              chunk_end;
	logic              push;
	digit_t            push_digit;
	logic              pop;
	logic              conv_done;

	assign neg_in = !op && (base == BaseW'(DecBase)) && value[ValueW-1];

	// power-of-two bases and hex mode: one digit per cycle
	always_comb begin
		digit_t mask;
		mask      = DigitW'((7'd1 << shamt_q) - 7'd1);
		digit_pow = DigitW'(work_q) & mask;
		work_pow  = work_q >> shamt_q;
	end

	// other bases: restoring division, one byte of the dividend per cycle
	always_comb begin
		logic [DigitW:0]   r;
		logic [ValueW-1:0] w;
		r = {1'b0, rem_q};
		w = work_q;
		for (int i = 0; i < ChunkBits; i++) begin
			r = {r[DigitW-1:0], w[ValueW-1]};
			w = {w[ValueW-2:0], 1'b0};
			if (r >= {1'b0, base_q}) begin
				r    = r - {1'b0, base_q};
				w[0] = 1'b1;
			end
		end
		work_div = w;
		rem_div  = r[DigitW-1:0];
	end

	assign chunk_end = (chunk_q == ChunkW'(ChunkCnt - 1));

	always_comb begin
		push       = 1'b0;
		push_digit = digit_pow;
		conv_done  = 1'b0;
		if (cmd.conv_step) begin
			if (shamt_q != '0) begin
				push      = 1'b1;
				conv_done = hex_q ? (depth_q == DepthW'(HexDigits - 1)) : (work_pow == '0);
			end else if (chunk_end) begin
				push       = 1'b1;
				push_digit = rem_div;
				conv_done  = (work_div == '0);
			end
		end
	end

	assign pop = (cmd.emit == EMIT_DIGIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
			depth_q <= '0;
		end else if (cmd.load) begin
			chunk_q <= '0;
			depth_q <= '0;
		end else begin
			if (cmd.conv_step && shamt_q == '0) begin
				chunk_q <= chunk_q + ChunkW'(1);
			end
			if (push) begin
				depth_q <= depth_q + DepthW'(1);
			end else if (pop) begin
				depth_q <= depth_q - DepthW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hex_q   <= op;
			base_q  <= base;
			neg_q   <= neg_in;
			shamt_q <= op ? ShiftW'(HexShift) : pow2_shift(base);
			work_q  <= neg_in ? (ValueW'(0) - ValueW'(value)) : ValueW'(value);
			rem_q   <= '0;
		end else if (cmd.conv_step) begin
			if (shamt_q != '0) begin
				work_q <= work_pow;
			end else begin
				work_q <= work_div;
				rem_q  <= chunk_end ? '0 : rem_div;
			end
		end
	end

	// digit stack: newest digit at the head, which is the most significant one
	always_ff @(posedge clk) begin
		if (push) begin
			stack_q[0] <= push_digit;
			for (int i = 1; i < StackDepth; i++) begin
				stack_q[i] <= stack_q[i-1];
			end
		end else if (pop) begin
			for (int i = 0; i < StackDepth - 1; i++) begin
				stack_q[i] <= stack_q[i+1];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != EMIT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.emit)
			EMIT_BAD: begin
				char_q <= CharNone;
				last_q <= 1'b1;
				bad_q  <= 1'b1;
			end
			EMIT_SIGN: begin
				char_q <= CharMinus;
				last_q <= (depth_q == '0);
				bad_q  <= 1'b0;
			end
			EMIT_DIGIT: begin
				char_q <= digit_char(stack_q[0], hex_q);
				last_q <= (depth_q == DepthW'(1));
				bad_q  <= 1'b0;
			end
			default: ;
		endcase
	end

	assign status.bad_in     = !op && ((base < BaseW'(MinBase)) || (base > BaseW'(MaxBase)));
	assign status.conv_done  = conv_done;
	assign status.neg        = neg_q;
	assign status.out_free   = !out_valid_q || !out_stall;
	assign status.last_digit = (depth_q == DepthW'(1));

	assign out_valid = out_valid_q;
	assign char_out  = char_q;
	assign last      = last_q;
	assign bad_base  = bad_q;

endmodule

@@ src/integer_to_ascii_digits.sv @@
// Top level of the integer to ASCII converter: controller plus datapath.
// Depends on itoa_pkg, itoa_ctrl and itoa_dp.
//
// One request carries op, a 64-bit value and a 6-bit base; the block answers
// with one character per output request, most significant first, last set on
// the final one. op 0 writes the value in base 2..36 with lower-case digits
// (a leading '-' only for a negative value in base ten, all other bases see
// the raw 64-bit pattern as unsigned); a bad base gives a single output with
// char_out 0, last 1 and bad_base 1. op 1 writes exactly 16 upper-case hex
// digits. Requests are handled one at a time: in_stall stays high from the
// cycle after acceptance until the last character has been loaded into the
// output register, so the next request can be taken while that character
// still waits on out_stall.
// Flow per request: accept, then digit extraction, then the characters, one per
// cycle without output back-pressure. Hex mode and power-of-two bases extract
// one digit per cycle by shifting. Other bases run a restoring division that
// consumes eight dividend bits per cycle and pushes a digit once the whole
// dividend has passed through: base ten gives at most 19 digits plus the sign,
// base three at most 41 digits.
module integer_to_ascii_digits import itoa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic signed [63:0] value,
	input  logic [5:0]         base,
	// character channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         char_out,
	output logic               last,
	output logic               bad_base
);

	cmd_t    cmd;
	status_t status;

	// sequencing: accept, then either flag a bad base or convert, optional sign, drain digit stack
	itoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// digit extraction, digit stack and output register
	itoa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.value     (value),
		.base      (base),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_out  (char_out),
		.last      (last),
		.bad_base  (bad_base)
	);

endmodule

@@ test/integer_to_ascii_digits_tb.sv @@
// Self-checking testbench for integer_to_ascii_digits: a directed table and then random requests,
// with every character compared against typed text or a predictor of the conversion.
// Depends on itoa_pkg and the integer_to_ascii_digits RTL only.
module integer_to_ascii_digits_tb import itoa_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OpRadix = 1'b0;
	localparam logic OpHex   = 1'b1;

	localparam int unsigned RandPhaseItems = 86;   // random requests per phase, in four phases
	localparam int unsigned DrainCycles    = 500;  // covers a base-three conversion
	localparam int unsigned MaxReports     = 10;

	// one request as it goes onto the input channel
	typedef struct packed {
		logic         op;
		logic [63:0]  value;
		base_t        base;
	} request_t;

	// one expected character on the output channel
	typedef struct packed {
		char_t ch;
		logic  last;
		logic  bad;
	} char_exp_t;

	// how the two channels hold back; applied per cycle
	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               op;
	logic signed [63:0] value;
	logic [5:0]         base;
	logic               out_valid;
	logic               out_stall;
	logic [7:0]         char_out;
	logic               last;
	logic               bad_base;

	idle_mode_t  idle_mode;
	char_exp_t   pending_chars[$];   // characters still owed by the block, oldest first
	int unsigned mismatches;

	// directed table: request, typed-in text (empty = use the predictor), typed bad base
	request_t dir_req[$];
	string    dir_text[$];
	logic     dir_bad[$];

	integer_to_ascii_digits u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.value     (value),
		.base      (base),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_out  (char_out),
		.last      (last),
		.bad_base  (bad_base)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop, far beyond the slowest legal run with worst stalls
	initial begin
		#20_000_000;
		$display("integer_to_ascii_digits_tb failed");
		$finish;
	end

	function automatic int unsigned sender_pct(idle_mode_t m);
		case (m)
			IDLE_SENDER: return 58;
			IDLE_BOTH:   return 24;
			default:     return 0;
		endcase
	endfunction

	function automatic int unsigned receiver_pct(idle_mode_t m);
		case (m)
			IDLE_RECEIVER: return 58;
			IDLE_BOTH:     return 24;
			default:       return 0;
		endcase
	endfunction

	// Predictor: queue the characters one request should produce.
	// Hex mode: 16 upper-case nibbles, top first, base ignored.
	// Radix mode: bad base -> single flagged result; base ten takes a sign,
	// every other base spells the raw 64-bit pattern as unsigned.
	function automatic void spell_number(request_t r);
		char_t       digits[$];
		logic [63:0] mag;
		logic        neg;
		logic [63:0] rem;
		if (r.op == OpHex) begin
			for (int k = HexDigits - 1; k >= 0; k--) begin
				rem = 64'(r.value[4*k +: 4]);
				pending_chars.push_back('{
					(rem < DecBase) ? CharZero + char_t'(rem) : CharUpA + char_t'(rem - DecBase),
					(k == 0), 1'b0});
			end
			return;
		end
		if (r.base < MinBase || r.base > MaxBase) begin
			pending_chars.push_back('{CharNone, 1'b1, 1'b1});
			return;
		end
		neg = (r.base == DecBase) && r.value[63];
		mag = neg ? (64'd0 - r.value) : r.value;   // most negative wraps to 2^63
		do begin
			rem = mag % 64'(r.base);
			digits.push_front((rem < DecBase) ? CharZero + char_t'(rem)
				: CharLowA + char_t'(rem - DecBase));
			mag = mag / 64'(r.base);
		end while (mag != 0);
		if (neg)
			pending_chars.push_back('{CharMinus, 1'b0, 1'b0});
		foreach (digits[i])
			pending_chars.push_back('{digits[i], (i == digits.size() - 1), 1'b0});
	endfunction

	function automatic void queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			pending_chars.push_back('{char_t'(s[i]), (i == s.len() - 1), 1'b0});
	endfunction

	function automatic void report(string msg);
		mismatches++;
		if (mismatches <= MaxReports)
			$display("%0t: %s", $realtime, msg);
	endfunction

	function automatic void add_row(logic o, logic [63:0] v, base_t b, string text, logic bad);
		dir_req.push_back('{o, v, b});
		dir_text.push_back(text);
		dir_bad.push_back(bad);
	endfunction

	// Random request: mostly legal bases with base ten and powers of two weighted up,
	// a few bad bases, and values spread over full-width, small, negative and
	// single-bit patterns so short and long digit strings both show up.
	function automatic request_t random_request();
		request_t    r;
		int unsigned pick;
		r.op = ($urandom_range(99) < 15) ? OpHex : OpRadix;
		pick = $urandom_range(99);
		if (r.op == OpHex || pick < 8) begin
			case ($urandom_range(2))
				0:       r.base = base_t'($urandom_range(MinBase - 1));
				1:       r.base = base_t'($urandom_range(63, MaxBase + 1));
				default: r.base = base_t'($urandom);
			endcase
		end else if (pick < 30) begin
			r.base = base_t'(DecBase);
		end else if (pick < 45) begin
			r.base = base_t'(1 << $urandom_range(5, 1));
		end else begin
			r.base = base_t'($urandom_range(MaxBase, MinBase));
		end
		pick = $urandom_range(99);
		if (pick < 40)
			r.value = {$urandom, $urandom};
		else if (pick < 60)
			r.value = 64'($urandom_range(1000));
		else if (pick < 75)
			r.value = 64'd0 - 64'($urandom_range(1000, 1));
		else if (pick < 85)
			r.value = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
		else
			r.value = {$urandom, $urandom} >> $urandom_range(63);
		return r;
	endfunction

	// Drive one request, holding it until the block takes it, then record what it owes.
	// Sender gaps put junk on the payload with valid low.
	task automatic issue(request_t r, string text, logic typed_bad);
		while ($urandom_range(99) < sender_pct(idle_mode)) begin
			in_valid <= 1'b0;
			op       <= 1'($urandom);
			value    <= {$urandom, $urandom};
			base     <= 6'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= r.op;
		value    <= r.value;
		base     <= r.base;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (typed_bad)
			pending_chars.push_back('{CharNone, 1'b1, 1'b1});
		else if (text.len() != 0)
			queue_text(text);
		else
			spell_number(r);
	endtask

	// Output side: take a character whenever valid and not stalled, compare it
	// with the oldest owed one, then pick the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_chars.size() == 0) begin
					report($sformatf("unexpected char %02h last %0b bad %0b",
						char_out, last, bad_base));
				end else if (pending_chars[0] != {char_out, last, bad_base}) begin
					report($sformatf("expected char %02h last %0b bad %0b, got %02h %0b %0b",
						pending_chars[0].ch, pending_chars[0].last, pending_chars[0].bad,
						char_out, last, bad_base));
					void'(pending_chars.pop_front());
				end else begin
					void'(pending_chars.pop_front());
				end
			end
			out_stall <= ($urandom_range(99) < receiver_pct(idle_mode));
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		op         = OpRadix;
		value      = '0;
		base       = '0;
		out_stall  = 1'b0;
		idle_mode  = IDLE_NONE;
		mismatches = 0;

		// Directed table. Typed text only where the answer is obvious; the rest
		// goes through the predictor.
		add_row(OpRadix, 64'd0,                  6'd10, "0", 1'b0);
		add_row(OpRadix, 64'd0,                  6'd2,  "0", 1'b0);
		add_row(OpRadix, 64'h7FFF_FFFF_FFFF_FFFF, 6'd10, "9223372036854775807", 1'b0);
		// most negative in base ten: magnitude wraps, sign still printed
		add_row(OpRadix, 64'h8000_0000_0000_0000, 6'd10, "-9223372036854775808", 1'b0);
		add_row(OpRadix, 64'hFFFF_FFFF_FFFF_FFFF, 6'd10, "-1", 1'b0);
		add_row(OpRadix, 64'hFFFF_FFFF_FFFF_FFF7, 6'd10, "-9", 1'b0);
		add_row(OpRadix, 64'd10,                 6'd10, "10", 1'b0);
		add_row(OpRadix, 64'd35,                 6'd36, "z", 1'b0);
		// negative in other bases: raw pattern, no sign; binary is the 64-char case
		add_row(OpRadix, 64'hFFFF_FFFF_FFFF_FFFF, 6'd16, "ffffffffffffffff", 1'b0);
		add_row(OpRadix, 64'hFFFF_FFFF_FFFF_FFFF, 6'd2,  "", 1'b0);
		add_row(OpRadix, 64'h8000_0000_0000_0000, 6'd2,  "", 1'b0);
		add_row(OpRadix, 64'hFFFF_FFFF_FFFF_FFFF, 6'd36, "", 1'b0);
		add_row(OpRadix, 64'hFFFF_FFFF_FFFF_FFDC, 6'd36, "", 1'b0);
		add_row(OpRadix, 64'h8000_0000_0000_0000, 6'd8,  "", 1'b0);
		add_row(OpRadix, 64'hFEDC_BA98_7654_3210, 6'd3,  "", 1'b0);
		add_row(OpRadix, 64'd100,                6'd32, "", 1'b0);
		add_row(OpRadix, 64'h0123_4567_89AB_CDEF, 6'd7,  "", 1'b0);
		// bad bases on both sides of the legal range
		add_row(OpRadix, 64'd5,                  6'd0,  "", 1'b1);
		add_row(OpRadix, 64'hFFFF_FFFF_FFFF_FFFF, 6'd1,  "", 1'b1);
		add_row(OpRadix, 64'd0,                  6'd37, "", 1'b1);
		add_row(OpRadix, 64'h8000_0000_0000_0000, 6'd63, "", 1'b1);
		// hex mode ignores the base, even a bad one
		add_row(OpHex,   64'd0,                  6'd0,  "0000000000000000", 1'b0);
		add_row(OpHex,   64'hFFFF_FFFF_FFFF_FFFF, 6'd63, "FFFFFFFFFFFFFFFF", 1'b0);
		add_row(OpHex,   64'h0123_4567_89AB_CDEF, 6'd5,  "0123456789ABCDEF", 1'b0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_mode = IDLE_BOTH;
		foreach (dir_req[i])
			issue(dir_req[i], dir_text[i], dir_bad[i]);

		// random requests, one phase per idling pattern
		for (int p = 0; p < 4; p++) begin
			case (p)
				0:       idle_mode = IDLE_NONE;
				1:       idle_mode = IDLE_SENDER;
				2:       idle_mode = IDLE_RECEIVER;
				default: idle_mode = IDLE_BOTH;
			endcase
			for (int n = 0; n < RandPhaseItems; n++)
				issue(random_request(), "", 1'b0);
		end
		in_valid <= 1'b0;

		// wait for every owed character, then give the block time to show extras
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0) begin
			$display("integer_to_ascii_digits_tb passed");
		end else begin
			$display("integer_to_ascii_digits_tb failed");
		end
		$finish;
	end

endmodule

@@ integer_to_ascii_digits.f @@
src/itoa_pkg.sv
src/itoa_ctrl.sv
src/itoa_dp.sv
src/integer_to_ascii_digits.sv
test/integer_to_ascii_digits_tb.sv
